[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/bmd_pkg.sv]
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants, register indexes and the per-site control bundle.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_PIXEL_BITS    = 8;
    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 16;
    localparam int CFG_INDEX_BITS    = 8;
    localparam int CFG_DATA_BITS     = 16;
    localparam int RESET_SIZE        = 256;
    localparam int MIN_SIZE          = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 8'd0,
        CFG_FRAME_HEIGHT = 8'd1
    } bmd_cfg_idx_t;

    // Parity, border position and row and frame end flags of one output site.
    typedef struct packed {
        logic odd_r;
        logic odd_c;
        logic top0;
        logic top1;
        logic bot0;
        logic bot1;
        logic lft0;
        logic lft1;
        logic rgt0;
        logic rgt1;
        logic eor;
        logic eof;
    } bmd_site_t;

endpackage

[src/bmd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/bmd_kernel.sv]
// ----------------------------------------------------------------------------
// Demosaic kernel
// Border reflection of the 5x5 window and the gradient-corrected sums.
// ----------------------------------------------------------------------------
module bmd_kernel #(
    parameter int PIXEL_BITS = bmd_pkg::DEF_PIXEL_BITS
) (
    input  logic [25*PIXEL_BITS-1:0] win,
    input  bmd_pkg::bmd_site_t       site,
    output logic [PIXEL_BITS-1:0]    red,
    output logic [PIXEL_BITS-1:0]    green,
    output logic [PIXEL_BITS-1:0]    blue
);

    localparam int P  = PIXEL_BITS;
    localparam int SW = PIXEL_BITS + 6;

    logic [P-1:0] w  [0:4][0:4];
    logic [P-1:0] rr [0:4][0:4];
    logic [P-1:0] t  [0:4][0:4];

    logic signed [SW-1:0] c, n1, s1, w1, e1, n2, s2, w2, e2, dg;
    logic signed [SW-1:0] k_green, k_horiz, k_vert, k_diag;
    logic [P-1:0] f_green, f_horiz, f_vert, f_diag;

    function automatic logic signed [SW-1:0] ext(input logic [P-1:0] x);
        ext = $signed({{(SW-P){1'b0}}, x});
    endfunction

    function automatic logic [P-1:0] finish(input logic signed [SW-1:0] sum);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] maxv;
        maxv = $signed({{(SW-P){1'b0}}, {P{1'b1}}});
        s = sum + $signed(SW'(8));
        v = s >>> 4;
        if (s[SW-1])
        begin
            finish = '0;
        end
        else if (v > maxv)
        begin
            finish = {P{1'b1}};
        end
        else
        begin
            finish = v[P-1:0];
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                w[i][j] = win[(i*5+j)*P +: P];
            end
        end
        // reflect rows about the frame edge
        for (int j = 0; j < 5; j++)
        begin
            rr[0][j] = site.top0 ? w[4][j] : (site.top1 ? w[2][j] : w[0][j]);
            rr[1][j] = site.top0 ? w[3][j] : w[1][j];
            rr[2][j] = w[2][j];
            rr[3][j] = site.bot0 ? w[1][j] : w[3][j];
            rr[4][j] = site.bot0 ? w[0][j] : (site.bot1 ? w[2][j] : w[4][j]);
        end
        // then columns
        for (int i = 0; i < 5; i++)
        begin
            t[i][0] = site.lft0 ? rr[i][4] : (site.lft1 ? rr[i][2] : rr[i][0]);
            t[i][1] = site.lft0 ? rr[i][3] : rr[i][1];
            t[i][2] = rr[i][2];
            t[i][3] = site.rgt0 ? rr[i][1] : rr[i][3];
            t[i][4] = site.rgt0 ? rr[i][0] : (site.rgt1 ? rr[i][2] : rr[i][4]);
        end
    end

    always_comb
    begin
        c  = ext(t[2][2]);
        n1 = ext(t[1][2]);
        s1 = ext(t[3][2]);
        w1 = ext(t[2][1]);
        e1 = ext(t[2][3]);
        n2 = ext(t[0][2]);
        s2 = ext(t[4][2]);
        w2 = ext(t[2][0]);
        e2 = ext(t[2][4]);
        dg = ext(t[1][1]) + ext(t[1][3]) + ext(t[3][1]) + ext(t[3][3]);

        k_green = (c <<< 3) + ((n1 + s1 + e1 + w1) <<< 2) - ((n2 + s2 + e2 + w2) <<< 1);
        k_horiz = (c <<< 3) + (c <<< 1) + ((w1 + e1) <<< 3) - ((w2 + e2) <<< 1)
                - (dg <<< 1) + n2 + s2;
        k_vert  = (c <<< 3) + (c <<< 1) + ((n1 + s1) <<< 3) - ((n2 + s2) <<< 1)
                - (dg <<< 1) + w2 + e2;
        k_diag  = (c <<< 3) + (c <<< 2) + (dg <<< 2)
                - ((n2 + s2 + w2 + e2) <<< 1) - (n2 + s2 + w2 + e2);

        f_green = finish(k_green);
        f_horiz = finish(k_horiz);
        f_vert  = finish(k_vert);
        f_diag  = finish(k_diag);
    end

    always_comb
    begin
        unique case ({site.odd_r, site.odd_c})
            2'b00:
            begin
                red   = f_horiz;
                green = t[2][2];
                blue  = f_vert;
            end
            2'b11:
            begin
                red   = f_vert;
                green = t[2][2];
                blue  = f_horiz;
            end
            2'b01:
            begin
                red   = t[2][2];
                green = f_green;
                blue  = f_diag;
            end
            default:
            begin
                red   = f_diag;
                green = f_green;
                blue  = t[2][2];
            end
        endcase
    end

endmodule

[src/bayer_mhc_demosaic_top.sv]
// Path: a result passes the stage-1 register, the window and stage-2 register, then the output register;
// output pixel (r,c) is caused by input position (r+2,c+2), drain beats included.
// Throughput: one beat per cycle while the skid stage is empty, set by one line store read and one write per cycle.
// A two-entry output register and skid stage keep input flowing while a result waits.
// Reset: counters, window and output clear at once; line store needs no clearing.
// ----------------------------------------------------------------------------
// Bayer MHC demosaic top level
// GRBG raster in, RGB out, a four-line store and a 5x5 gradient-corrected window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bayer_mhc_demosaic_top #(
    parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bmd_pkg::DEF_PIXEL_BITS
) (
    input  logic clk,
    input  logic rst_n,
    // fields: raw_pixel
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_tdata,
    // fields: drain
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields: red, green, blue
    output logic [((3*PIXEL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast,
    // fields: end_of_frame
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bmd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int P     = PIXEL_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int HB    = bmd_pkg::FRAME_HEIGHT_BITS;
    localparam int RW    = HB + 1;
    localparam int OUT_W = ((3*PIXEL_BITS+7)/8)*8;
    localparam int RST_W = (bmd_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                             : bmd_pkg::RESET_SIZE;

    typedef struct packed {
        logic [P-1:0] red;
        logic [P-1:0] green;
        logic [P-1:0] blue;
        logic         eor;
        logic         eof;
    } bmd_pix_t;

    // configuration
    logic [bmd_pkg::FRAME_WIDTH_BITS-1:0] fw_reg;
    logic [HB-1:0]                        fh_reg;

    // frame state
    logic [WW-1:0] ew_reg;
    logic [HB-1:0] eh_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] in_col_reg;
    logic [HB-1:0] out_row_reg;
    logic [CW-1:0] out_col_reg;

    // pipeline
    logic               s1_valid_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [P-1:0]       s1_sample_reg;
    logic               s1_res_reg;
    bmd_pkg::bmd_site_t s1_site_reg;
    logic               s2_valid_reg;
    bmd_pkg::bmd_site_t s2_site_reg;
    logic [P-1:0]       win_reg [0:4][0:4];
    logic [25*P-1:0]    win_flat;

    bmd_pix_t m_reg;
    logic     m_valid_reg;
    bmd_pix_t skid_reg;
    logic     skid_valid_reg;

    logic          adv, accept, start, live, drain_in, ignore, latch, take;
    logic [31:0]   fw32, fh32, w_cl32, h_cl32;
    logic [WW-1:0] ew;
    logic [HB-1:0] eh;
    logic          col_last, res, eor, eof;
    logic [P-1:0]  sample;
    logic [4*P-1:0] ram_rdata;
    logic [4*P-1:0] ram_wdata;
    bmd_pkg::bmd_site_t site;
    bmd_pix_t      new_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= bmd_pkg::FRAME_WIDTH_BITS'(bmd_pkg::RESET_SIZE);
            fh_reg <= HB'(bmd_pkg::RESET_SIZE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bmd_pkg::CFG_FRAME_WIDTH)
            begin
                fw_reg <= cfg_data[bmd_pkg::FRAME_WIDTH_BITS-1:0];
            end
            else if (cfg_index == bmd_pkg::CFG_FRAME_HEIGHT)
            begin
                fh_reg <= cfg_data[HB-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side control
    // ------------------------------------------------------------------
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign drain_in = s_tuser[0];

    always_comb
    begin
        start  = (in_row_reg == '0) && (in_col_reg == '0);
        live   = (in_row_reg < {1'b0, eh_reg}) || start;
        ignore = live && drain_in;
        latch  = start && !drain_in;

        fw32 = 32'(fw_reg);
        fh32 = 32'(fh_reg);
        if (fw32 < 32'(bmd_pkg::MIN_SIZE))
        begin
            w_cl32 = 32'(bmd_pkg::MIN_SIZE);
        end
        else if (fw32 > 32'(MAX_WIDTH))
        begin
            w_cl32 = 32'(MAX_WIDTH);
        end
        else
        begin
            w_cl32 = fw32;
        end
        h_cl32 = (fh32 < 32'(bmd_pkg::MIN_SIZE)) ? 32'(bmd_pkg::MIN_SIZE) : fh32;

        ew = latch ? w_cl32[WW-1:0] : ew_reg;
        eh = latch ? h_cl32[HB-1:0] : eh_reg;

        sample   = live ? s_tdata[P-1:0] : '0;
        col_last = ({1'b0, in_col_reg} + WW'(1)) == ew;
        res      = (in_row_reg > RW'(2)) || ((in_row_reg == RW'(2)) && (in_col_reg >= CW'(2)));
        eor      = ({1'b0, out_col_reg} + WW'(1)) == ew;
        eof      = eor && (({1'b0, out_row_reg} + RW'(1)) == {1'b0, eh});

        site.odd_r = out_row_reg[0];
        site.odd_c = out_col_reg[0];
        site.top0  = out_row_reg == HB'(0);
        site.top1  = out_row_reg == HB'(1);
        site.bot0  = out_row_reg == (eh - HB'(1));
        site.bot1  = out_row_reg == (eh - HB'(2));
        site.lft0  = out_col_reg == CW'(0);
        site.lft1  = out_col_reg == CW'(1);
        site.rgt0  = {1'b0, out_col_reg} == (ew - WW'(1));
        site.rgt1  = {1'b0, out_col_reg} == (ew - WW'(2));
        site.eor   = eor;
        site.eof   = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg      <= WW'(RST_W);
            eh_reg      <= HB'(bmd_pkg::RESET_SIZE);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (accept && !ignore)
        begin
            if (latch)
            begin
                ew_reg <= ew;
                eh_reg <= eh;
            end
            if (res && eof)
            begin
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
            end
            else
            begin
                in_col_reg <= col_last ? '0 : in_col_reg + CW'(1);
                in_row_reg <= col_last ? in_row_reg + RW'(1) : in_row_reg;
                if (res)
                begin
                    out_col_reg <= eor ? '0 : out_col_reg + CW'(1);
                    out_row_reg <= eor ? out_row_reg + HB'(1) : out_row_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: four rows per column word
    // ------------------------------------------------------------------
    assign ram_wdata = {s1_sample_reg, ram_rdata[4*P-1:P]};

    bmd_ram #(
        .WIDTH (4*P),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (accept && !ignore),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept && !ignore;
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                s1_col_reg    <= in_col_reg;
                s1_sample_reg <= sample;
                s1_res_reg    <= res;
                s1_site_reg   <= site;
            end
            s2_site_reg <= s1_site_reg;
        end
    end

    // shift the window left, new column from the line store and the incoming sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (adv && s1_valid_reg)
        begin
            for (int k = 0; k < 5; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j+1];
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                win_reg[k][4] <= ram_rdata[k*P +: P];
            end
            win_reg[4][4] <= s1_sample_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                win_flat[(k*5+j)*P +: P] = win_reg[k][j];
            end
        end
    end

    bmd_kernel #(
        .PIXEL_BITS (P)
    ) u_kernel (
        .win   (win_flat),
        .site  (s2_site_reg),
        .red   (new_pix.red),
        .green (new_pix.green),
        .blue  (new_pix.blue)
    );

    assign new_pix.eor = s2_site_reg.eor;
    assign new_pix.eof = s2_site_reg.eof;

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    assign take = m_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !m_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                m_valid_reg <= adv && s2_valid_reg;
            end
        end
        else if (adv && s2_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !m_valid_reg)
        begin
            m_reg <= skid_valid_reg ? skid_reg : new_pix;
        end
        else if (adv && s2_valid_reg)
        begin
            skid_reg <= new_pix;
        end
    end

    assign m_tdata  = OUT_W'({m_reg.blue, m_reg.green, m_reg.red});
    assign m_tlast  = m_reg.eor;
    assign m_tuser  = m_reg.eof;
    assign m_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `ASSERT_IMPL(a_eof_on_row_end, m_valid_reg && m_reg.eof, m_reg.eor)
    `ASSERT_NEXT(a_frame_restart, accept && !ignore && res && eof,
                 in_row_reg == '0 && in_col_reg == '0 && out_row_reg == '0)

endmodule

[test/bayer_mhc_demosaic_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bayer MHC demosaic testbench
// Streams small GRBG frames with drain beats through the block. Frame sizes
// change between frames. The scoreboard predicts every RGB beat with its
// row and frame flags, and checks the results in order. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic       eof;
    logic       eor;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
} rgb_beat_t;

class demosaic_scoreboard;
    localparam int LW = 1024;
    bit [7:0]    lines[4*LW];
    bit [7:0]    win[5][5];
    int unsigned in_r, in_c, out_r, out_c;
    int unsigned reg_w, reg_h, act_w, act_h;
    rgb_beat_t   pending[$];
    int          errors;

    function new();
        foreach (lines[i]) lines[i] = 0;
        foreach (win[i, j]) win[i][j] = 0;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        reg_w = bmd_pkg::RESET_SIZE; reg_h = bmd_pkg::RESET_SIZE;
        act_w = bmd_pkg::RESET_SIZE; act_h = bmd_pkg::RESET_SIZE;
        errors = 0;
    endfunction

    function void set_reg(bmd_pkg::bmd_cfg_idx_t idx, bit [15:0] val);
        if (idx == bmd_pkg::CFG_FRAME_WIDTH) reg_w = val[10:0];
        else if (idx == bmd_pkg::CFG_FRAME_HEIGHT) reg_h = val;
    endfunction

    function bit at_frame_start();
        return in_r == 0 && in_c == 0;
    endfunction

    function int reflect(int k, int n);
        if (k < 0) return -k;
        if (k >= n) return 2 * n - 2 - k;
        return k;
    endfunction

    function int tap(int dr, int dc);
        int rr;
        int cc;
        rr = reflect(int'(out_r) + dr, int'(act_h)) - int'(out_r) + 2;
        cc = reflect(int'(out_c) + dc, int'(act_w)) - int'(out_c) + 2;
        if (rr < 0) rr = 0;
        if (rr > 4) rr = 4;
        if (cc < 0) cc = 0;
        if (cc > 4) cc = 4;
        return int'(win[rr][cc]);
    endfunction

    // round half up from sixteenths, clamp to 0..255
    function bit [7:0] round_clamp(int sum);
        int s;
        s = sum + 8;
        if (s < 0) return 8'd0;
        s = s >>> 4;
        if (s > 255) s = 255;
        return s[7:0];
    endfunction

    function int diag_sum();
        return tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1);
    endfunction

    function int green_at_rb();
        return 8 * tap(0, 0) + 4 * (tap(-1, 0) + tap(1, 0) + tap(0, -1) + tap(0, 1))
             - 2 * (tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2));
    endfunction

    function int across_row();
        return 10 * tap(0, 0) + 8 * (tap(0, -1) + tap(0, 1))
             - 2 * (tap(0, -2) + tap(0, 2)) - 2 * diag_sum() + tap(-2, 0) + tap(2, 0);
    endfunction

    function int across_col();
        return 10 * tap(0, 0) + 8 * (tap(-1, 0) + tap(1, 0))
             - 2 * (tap(-2, 0) + tap(2, 0)) - 2 * diag_sum() + tap(0, -2) + tap(0, 2);
    endfunction

    function int opposite_color();
        return 12 * tap(0, 0) + 4 * diag_sum()
             - 3 * (tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2));
    endfunction

    function void note_input(bit [7:0] pix, bit drn);
        bit [7:0]    sample;
        bit [7:0]    col_v[5];
        int unsigned r0, c0, col;
        rgb_beat_t   e;
        sample = 0;
        r0 = in_r;
        c0 = in_c;
        if (in_r < act_h || (in_r == 0 && in_c == 0)) begin
            // drop drain beats inside a frame
            if (drn) return;
            if (in_r == 0 && in_c == 0) begin
                act_w = reg_w < bmd_pkg::MIN_SIZE ? bmd_pkg::MIN_SIZE : reg_w;
                if (act_w > LW) act_w = LW;
                act_h = reg_h < bmd_pkg::MIN_SIZE ? bmd_pkg::MIN_SIZE : reg_h;
            end
            sample = pix;
        end
        col = in_c < act_w ? in_c : 0;
        for (int k = 0; k < 4; k++) col_v[k] = lines[k*LW + col];
        col_v[4] = sample;
        for (int k = 0; k < 4; k++) lines[k*LW + col] = col_v[k+1];
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 4; j++) win[k][j] = win[k][j+1];
            win[k][4] = col_v[k];
        end
        in_c++;
        if (in_c >= act_w) begin
            in_c = 0;
            in_r++;
        end
        if (!(r0 > 2 || (r0 == 2 && c0 >= 2))) return;
        case ({out_r[0], out_c[0]})
            2'b00: begin
                e.red = round_clamp(across_row());
                e.green = 8'(tap(0, 0));
                e.blue = round_clamp(across_col());
            end
            2'b11: begin
                e.red = round_clamp(across_col());
                e.green = 8'(tap(0, 0));
                e.blue = round_clamp(across_row());
            end
            2'b01: begin
                e.red = 8'(tap(0, 0));
                e.green = round_clamp(green_at_rb());
                e.blue = round_clamp(opposite_color());
            end
            default: begin
                e.red = round_clamp(opposite_color());
                e.green = round_clamp(green_at_rb());
                e.blue = 8'(tap(0, 0));
            end
        endcase
        e.eor = (out_c + 1 == act_w);
        e.eof = e.eor && (out_r + 1 == act_h);
        pending.push_back(e);
        out_c++;
        if (out_c >= act_w) begin
            out_c = 0;
            out_r++;
        end
        if (e.eof) begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
    endfunction

    function void check(rgb_beat_t got);
        rgb_beat_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected beat %h", got);
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            errors++;
            if (errors <= 10)
                $display({"ERROR: rgb beat mismatch exp r=%0d g=%0d b=%0d eor=%0b eof=%0b,",
                          " got r=%0d g=%0d b=%0d eor=%0b eof=%0b"},
                         e.red, e.green, e.blue, e.eor, e.eof,
                         got.red, got.green, got.blue, got.eor, got.eof);
        end
    endfunction
endclass

module bayer_mhc_demosaic_top_tb;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [bmd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bmd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    demosaic_scoreboard sb;
    bit calm;
    int stall_cycles = 0;
    int pixels_sent;

    bayer_mhc_demosaic_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #2 clk = ~clk;

    // output side: check the beat, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check({m_tuser[0], m_tlast, m_tdata});
        m_tready <= calm || ($urandom_range(99) >= 19);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(bit [7:0] pix, bit drn);
        if (!calm)
            while ($urandom_range(99) < 19) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= drn;
        do @(posedge clk); while (!s_tready);
        sb.note_input(pix, drn);
        pixels_sent++;
    endtask

    task automatic write_reg(bmd_pkg::bmd_cfg_idx_t idx, bit [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // mode 0 random, 1 random extremes, 2 lit or dark by site parity against a fresh random bit
    function automatic bit [7:0] pick_pixel(int mode, int unsigned idx, int unsigned w);
        int unsigned r;
        int unsigned c;
        r = idx / w;
        c = idx % w;
        case (mode)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return ((r[0] ^ c[0]) == $urandom_range(1)) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic run_frame(int mode, bit noise);
        int unsigned w;
        int unsigned h;
        w = sb.reg_w < bmd_pkg::MIN_SIZE ? bmd_pkg::MIN_SIZE
                                         : (sb.reg_w > 1024 ? 1024 : sb.reg_w);
        h = sb.reg_h < bmd_pkg::MIN_SIZE ? bmd_pkg::MIN_SIZE : sb.reg_h;
        // a drain at frame start is ignored
        if (noise) send_beat(8'($urandom_range(255)), 1'b1);
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(99) < 4) send_beat(8'($urandom_range(255)), 1'b1);
            send_beat(pick_pixel(mode, i, w), 1'b0);
        end
        // flush; a pixel here counts as a drain
        while (!sb.at_frame_start())
            send_beat(8'($urandom_range(255)),
                      (noise && $urandom_range(99) < 20) ? 1'b0 : 1'b1);
        wait_idle();
    endtask

    initial begin
        int frame_no;
        sb = new();
        calm = 0;
        pixels_sent = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        cfg_valid = 0;
        cfg_index = bmd_pkg::CFG_FRAME_WIDTH;
        cfg_data = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // below the minimum, clamped up to 8 x 8
        write_reg(bmd_pkg::CFG_FRAME_WIDTH, 16'd0);
        write_reg(bmd_pkg::CFG_FRAME_HEIGHT, 16'd0);
        run_frame(2, 1'b1);
        run_frame(1, 1'b0);
        // a wider line; the huge height is replaced before the frame starts
        write_reg(bmd_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(bmd_pkg::CFG_FRAME_WIDTH, 16'd32);
        write_reg(bmd_pkg::CFG_FRAME_HEIGHT, 16'd8);
        run_frame(0, 1'b1);
        write_reg(bmd_pkg::CFG_FRAME_WIDTH, 16'd8);
        write_reg(bmd_pkg::CFG_FRAME_HEIGHT, 16'd8);

        frame_no = 0;
        while (pixels_sent < 1100) begin
            calm = (frame_no == 1);
            if ($urandom_range(3) != 0)
                write_reg(bmd_pkg::CFG_FRAME_WIDTH, 16'(2 * $urandom_range(4, 12)));
            if ($urandom_range(3) != 0)
                write_reg(bmd_pkg::CFG_FRAME_HEIGHT, 16'(2 * $urandom_range(4, 6)));
            run_frame(($urandom_range(9) < 7) ? 0 : int'($urandom_range(1, 2)), 1'b1);
            frame_no++;
        end
        calm = 0;

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[bayer_mhc_demosaic_top.f]
+incdir+src
src/bmd_pkg.sv
src/bmd_ram.sv
src/bmd_kernel.sv
src/bayer_mhc_demosaic_top.sv
test/bayer_mhc_demosaic_top_tb.sv
